// ===== hdl/brlne_pkg.sv =====
// Shared types and constants for the bit run-length nibble encoder.
// Used by the front scanner, the run queue and the back packer; no dependencies.
package brlne_pkg;

    localparam int unsigned BITS_PER_BYTE = 8;
    localparam int unsigned NIB_W         = 4;
    localparam int unsigned LEN_W         = 3;
    // Up to one closed run per scanned bit plus the flushed run at stream end.
    localparam int unsigned MAX_NIBS      = BITS_PER_BYTE + 1;
    localparam int unsigned CNT_W         = $clog2(MAX_NIBS + 1);
    localparam int unsigned RUN_W         = 4;
    localparam int unsigned CFG_W         = 3;
    localparam logic [CFG_W-1:0] CFG_RESET = 3'd7;

    typedef logic [NIB_W-1:0] t_nib;

    // One queue entry: the run nibbles closed by one input byte, in order.
    typedef struct packed {
        t_nib [MAX_NIBS-1:0] nibs;
        logic [CNT_W-1:0]    count;
        logic                last;
    } t_entry;

endpackage

// ===== hdl/brlne_front.sv =====
// Front scanner: accepts input bytes, splits their bits into runs and emits closed-run nibbles.
// Depends on brlne_pkg.
module brlne_front
    import brlne_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_max_run,
    input  logic             i_valid,
    input  logic [7:0]       i_data,
    input  logic             i_last,
    input  logic             i_full,
    output logic             o_ready,
    output logic             o_push,
    output t_entry           o_entry
);

    logic             r_run_bit;
    logic [RUN_W-1:0] r_run_len;
    logic             r_first;
    logic             n_run_bit;
    logic [RUN_W-1:0] n_run_len;
    logic             n_first;
    logic [RUN_W-1:0] w_limit;

    function automatic t_nib make_nib(input logic b, input logic [RUN_W-1:0] len);
        logic [RUN_W-1:0] lm1;
        lm1 = len - RUN_W'(1);
        return {b, lm1[LEN_W-1:0]};
    endfunction

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign w_limit = {1'b0, i_max_run} + RUN_W'(1);

    // Eight narrow dependent steps, one per bit, least significant first.
    always_comb begin
        n_run_bit       = r_run_bit;
        n_run_len       = r_run_len;
        n_first         = r_first;
        o_entry.nibs    = '0;
        o_entry.count   = '0;
        o_entry.last    = i_last;
        for (int i = 0; i < BITS_PER_BYTE; i++) begin
            if (n_first || n_run_len == '0) begin
                n_run_bit = i_data[i];
                n_first   = 1'b0;
                n_run_len = RUN_W'(1);
            end else if (i_data[i] != n_run_bit || n_run_len >= w_limit) begin
                o_entry.nibs[o_entry.count] = make_nib(n_run_bit, n_run_len);
                o_entry.count = o_entry.count + CNT_W'(1);
                n_run_bit = i_data[i];
                n_run_len = RUN_W'(1);
            end else begin
                n_run_len = n_run_len + RUN_W'(1);
            end
        end
        // At stream end the open run is flushed and the scanner starts over.
        if (i_last) begin
            o_entry.nibs[o_entry.count] = make_nib(n_run_bit, n_run_len);
            o_entry.count = o_entry.count + CNT_W'(1);
            n_run_bit = 1'b0;
            n_run_len = '0;
            n_first   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_bit <= 1'b0;
            r_run_len <= '0;
            r_first   <= 1'b1;
        end else if (o_push) begin
            r_run_bit <= n_run_bit;
            r_run_len <= n_run_len;
            r_first   <= n_first;
        end
    end

endmodule

// ===== hdl/brlne_queue.sv =====
// Short FIFO of run entries between the front scanner and the back packer.
// Depends on brlne_pkg.
module brlne_queue
    import brlne_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_entry o_entry
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned FILL_W = $clog2(DEPTH + 1);

    t_entry              r_slots [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [FILL_W-1:0]   r_fill;
    logic                w_push;
    logic                w_pop;

    assign o_full  = (r_fill == FILL_W'(DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_entry = r_slots[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slots[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= wrap_inc(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= wrap_inc(r_rd_ptr);
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + FILL_W'(1);
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - FILL_W'(1);
            end
        end
    end

endmodule

// ===== hdl/brlne_back.sv =====
// Back packer: pairs nibbles into bytes, one per cycle unless stalled, and pads at stream end.
// Depends on brlne_pkg.
module brlne_back
    import brlne_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_entry     i_entry,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_last,
    output logic       o_pad
);

    logic [CNT_W-1:0] r_pos;
    t_nib             r_held;
    logic             r_held_v;
    logic             r_ovalid;
    logic [7:0]       r_obyte;
    logic             r_olast;
    logic             r_opad;

    logic [CNT_W-1:0] n_pos;
    t_nib             n_held;
    logic             n_held_v;
    logic             n_ovalid;
    logic [7:0]       n_obyte;
    logic             n_olast;
    logic             n_opad;

    logic             w_advance;
    logic [CNT_W-1:0] w_avail;
    logic [CNT_W-1:0] w_rem;
    logic [CNT_W-1:0] w_newpos;
    t_nib             w_nib0;
    t_nib             w_nib1;
    t_nib             w_nib2;
    logic             w_emit;

    function automatic t_nib pick(input t_entry e, input logic [CNT_W-1:0] idx);
        return (idx < CNT_W'(MAX_NIBS)) ? e.nibs[idx] : '0;
    endfunction

    assign w_advance = !r_ovalid || i_ready;
    assign w_avail   = i_entry.count - r_pos;
    assign w_nib0    = pick(i_entry, r_pos);
    assign w_nib1    = pick(i_entry, r_pos + CNT_W'(1));
    assign w_nib2    = pick(i_entry, r_pos + CNT_W'(2));

    always_comb begin
        n_pos    = r_pos;
        n_held   = r_held;
        n_held_v = r_held_v;
        n_ovalid = r_ovalid && !i_ready;
        n_obyte  = r_obyte;
        n_olast  = r_olast;
        n_opad   = r_opad;
        o_pop    = 1'b0;
        w_emit   = 1'b0;
        w_rem    = '0;
        w_newpos = r_pos;
        if (w_advance && !i_empty) begin
            n_olast = 1'b0;
            n_opad  = 1'b0;
            if (r_held_v) begin
                if (w_avail == '0) begin
                    o_pop = 1'b1;
                    if (i_entry.last) begin
                        n_ovalid = 1'b1;
                        n_obyte  = {r_held, t_nib'(0)};
                        n_olast  = 1'b1;
                        n_opad   = 1'b1;
                        n_held_v = 1'b0;
                    end
                end else begin
                    w_emit   = 1'b1;
                    n_obyte  = {r_held, w_nib0};
                    n_held_v = 1'b0;
                    w_rem    = w_avail - CNT_W'(1);
                    w_newpos = r_pos + CNT_W'(1);
                end
            end else begin
                if (w_avail == '0) begin
                    o_pop = 1'b1;
                end else if (w_avail == CNT_W'(1)) begin
                    o_pop = 1'b1;
                    if (i_entry.last) begin
                        n_ovalid = 1'b1;
                        n_obyte  = {w_nib0, t_nib'(0)};
                        n_olast  = 1'b1;
                        n_opad   = 1'b1;
                    end else begin
                        n_held   = w_nib0;
                        n_held_v = 1'b1;
                    end
                end else begin
                    w_emit   = 1'b1;
                    n_obyte  = {w_nib0, w_nib1};
                    w_rem    = w_avail - CNT_W'(2);
                    w_newpos = r_pos + CNT_W'(2);
                end
            end
            if (w_emit) begin
                n_ovalid = 1'b1;
                // The byte closes this entry when nothing, or only a nibble to hold, remains.
                if (w_rem == '0) begin
                    n_olast = 1'b1;
                    o_pop   = 1'b1;
                end else if (w_rem == CNT_W'(1) && !i_entry.last) begin
                    n_olast  = 1'b1;
                    o_pop    = 1'b1;
                    n_held   = (r_held_v) ? w_nib1 : w_nib2;
                    n_held_v = 1'b1;
                end else begin
                    n_pos = w_newpos;
                end
            end
            if (o_pop) begin
                n_pos = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_held  <= n_held;
        r_obyte <= n_obyte;
        r_olast <= n_olast;
        r_opad  <= n_opad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_held_v <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_held_v <= n_held_v;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_valid = r_ovalid;
    assign o_byte  = r_obyte;
    assign o_last  = r_olast;
    assign o_pad   = r_opad;

endmodule

// ===== hdl/bit_run_length_nibble_encoder_core.sv =====
// Bit run-length nibble encoder, top level: front scanner, run queue and back packer.
// Path: the entry of an input transfer is registered in the queue, and its first output byte
// in the output register; earlier entries and a stalled output can hold it back.
// Throughput: the front takes one byte per cycle while the queue has room; the back
// packer sends at most one output byte per cycle, and only while m_axis_tready is high.
// Reset (i_rst_n low, synchronous) empties the queue and output register, clears
// the run state and held nibble, and sets max_run_minus_one to 7.
module bit_run_length_nibble_encoder_core
    import brlne_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,     // max_run_minus_one
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] data_byte
    input  logic             s_axis_tlast,   // end_of_input
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
    output logic             m_axis_tlast,   // last_of_run
    output logic             m_axis_tuser    // [0] pad_nibbles
);

    logic [CFG_W-1:0] r_max_run;
    logic             w_push;
    logic             w_full;
    logic             w_empty;
    logic             w_pop;
    t_entry           w_front_entry;
    t_entry           w_head_entry;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_run <= CFG_RESET;
        end else if (i_cfg_valid) begin
            r_max_run <= i_cfg_data;
        end
    end

    brlne_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_max_run (r_max_run),
        .i_valid   (s_axis_tvalid),
        .i_data    (s_axis_tdata),
        .i_last    (s_axis_tlast),
        .i_full    (w_full),
        .o_ready   (s_axis_tready),
        .o_push    (w_push),
        .o_entry   (w_front_entry)
    );

    brlne_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_front_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_entry (w_head_entry)
    );

    brlne_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_entry (w_head_entry),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_byte  (m_axis_tdata),
        .o_last  (m_axis_tlast),
        .o_pad   (m_axis_tuser)
    );

endmodule

// ===== hdl/brlne_checker.sv =====
// Port-level checks for the bit run-length nibble encoder, bound to the top level.
// Depends on brlne_pkg and bit_run_length_nibble_encoder_core.
module brlne_checker
    import brlne_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic       m_axis_tuser
);

    // A stalled output transfer keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    // A pad nibble only ever sits in the closing byte of a stream end.
    a_pad_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[3:0] == 4'd0))
        else $error("pad byte not last or low nibble not zero");

    // Reset leaves nothing to send and room for input.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("output valid or input blocked after reset");

endmodule

bind bit_run_length_nibble_encoder_core brlne_checker u_brlne_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
